### rtl/fpbp_pkg.sv
package fpbp_pkg;

    // Default sizing of the block table.
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed widths of the request and result fields.
    localparam int BLOCK_FIELD_W = 4;
    localparam int SIZE_FIELD_W  = 16;
    localparam int COUNT_W       = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 5;

    // Selection rule; the unused code behaves as first fit.
    typedef enum logic [1:0] {
        POLICY_FIRST = 2'd0,
        POLICY_BEST  = 2'd1,
        POLICY_WORST = 2'd2
    } policy_t;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

    // Request operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PLACE = 1'b1;

endpackage

### rtl/fpbp_cell.sv
module fpbp_cell #(
    parameter int INDEX     = 0,
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fpbp_pkg::policy_t                  fit_policy,
    input  logic [fpbp_pkg::COUNT_W-1:0]       blocks_in_use,
    input  logic                               load_valid,
    input  logic [fpbp_pkg::BLOCK_FIELD_W-1:0] load_index,
    input  logic [SIZE_BITS-1:0]               load_size,
    input  logic                               commit_valid,
    input  logic [IDX_W-1:0]                   commit_index,
    input  logic                               tok_valid_in,
    input  logic                               tok_have_in,
    input  logic [IDX_W-1:0]                   tok_idx_in,
    input  logic [SIZE_BITS-1:0]               tok_left_in,
    input  logic [SIZE_BITS-1:0]               tok_size_in,
    output logic                               tok_valid_out,
    output logic                               tok_have_out,
    output logic [IDX_W-1:0]                   tok_idx_out,
    output logic [SIZE_BITS-1:0]               tok_left_out,
    output logic [SIZE_BITS-1:0]               tok_size_out
);
    import fpbp_pkg::*;

    localparam logic [IDX_W-1:0] OWN_IDX = IDX_W'(INDEX);

    logic                 used_reg;
    logic                 used_next;
    logic [SIZE_BITS-1:0] size_reg;
    logic                 tok_valid_reg;
    logic                 tok_have_reg;
    logic                 tok_have_next;
    logic [IDX_W-1:0]     tok_idx_reg;
    logic [IDX_W-1:0]     tok_idx_next;
    logic [SIZE_BITS-1:0] tok_left_reg;
    logic [SIZE_BITS-1:0] tok_left_next;
    logic [SIZE_BITS-1:0] tok_size_reg;

    logic                 load_hit;
    logic                 active;
    logic                 cand;
    logic                 better;
    logic                 take;
    logic [SIZE_BITS-1:0] left;

    assign load_hit = load_valid && (int'(load_index) == INDEX);
    assign active   = int'(blocks_in_use) > INDEX;

    // This block is a candidate when it is in range, free and big enough.
    assign cand = tok_valid_in && active && !used_reg && (size_reg >= tok_size_in);
    assign left = size_reg - tok_size_in;

    // Replacement rule against the best so far; ties keep the lower index.
    always_comb
    begin
        unique case (fit_policy)
            POLICY_BEST:  better = left < tok_left_in;
            POLICY_WORST: better = left > tok_left_in;
            default:      better = 1'b0;
        endcase
    end

    assign take = cand && (!tok_have_in || better);

    always_comb
    begin
        tok_have_next = tok_have_in || cand;
        tok_idx_next  = take ? OWN_IDX : tok_idx_in;
        tok_left_next = take ? left : tok_left_in;
    end

    // A load frees the block; the commit of a placement marks it used.
    always_comb
    begin
        priority if (load_hit)
            used_next = 1'b0;
        else if (commit_valid && (commit_index == OWN_IDX))
            used_next = 1'b1;
        else
            used_next = used_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            tok_valid_reg <= tok_valid_in;
        end
    end

    // Block size and the scan token's payload.
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            size_reg <= load_size;
        end
        tok_have_reg <= tok_have_next;
        tok_idx_reg  <= tok_idx_next;
        tok_left_reg <= tok_left_next;
        tok_size_reg <= tok_size_in;
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_have_out  = tok_have_reg;
    assign tok_idx_out   = tok_idx_reg;
    assign tok_left_out  = tok_left_reg;
    assign tok_size_out  = tok_size_reg;

endmodule

### rtl/fit_policy_block_placement.sv
// Fixed-partition block placement engine.
// Input channel (in_valid/in_ready) carries operation, block_index and item_size.
// A load request writes one block size into the table and marks that block free;
// it produces no result. A place request sends a token down
// a row of NUM_BLOCKS cells, one cell per cycle, each holding one block's size
// and used flag. The token keeps the best candidate under the configured policy
// (first, best or worst fit, ties to the lower index).
// Output channel (out_valid/out_ready) carries found, chosen_block and leftover.
// A place result passes from the last cell into a holding register and then into
// the output register; no new request is taken until it has left the holding
// register, so the block works on one place request at a time.
// Configuration (cfg_write, cfg_index, cfg_data) must be written while idle,
// unchecked by the block: register 0 selects the policy, register 1 the number of
// blocks scanned. Reset marks every block free and clears both registers; block
// sizes are undefined until loaded. If the receiver stalls, the finished result
// waits in a holding register and no new request is accepted until it has moved
// into the output register; the chosen block is marked used at that moment.
module fit_policy_block_placement #(
    parameter int NUM_BLOCKS = fpbp_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpbp_pkg::SIZE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fpbp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fpbp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [fpbp_pkg::BLOCK_FIELD_W-1:0] block_index,
    input  logic [fpbp_pkg::SIZE_FIELD_W-1:0]  item_size,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [fpbp_pkg::BLOCK_FIELD_W-1:0] chosen_block,
    output logic [fpbp_pkg::SIZE_FIELD_W-1:0]  leftover
);
    import fpbp_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    // Configuration registers.
    policy_t              fit_policy_reg;
    logic [COUNT_W-1:0]   blocks_in_use_reg;

    // Control state.
    logic                 busy_reg;
    logic                 busy_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    // Held and delivered results.
    logic                 pend_found_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [SIZE_BITS-1:0] pend_left_reg;
    logic                 found_reg;
    logic [BLOCK_FIELD_W-1:0] chosen_reg;
    logic [SIZE_FIELD_W-1:0]  leftover_reg;

    logic                 accept;
    logic                 place_start;
    logic                 load_valid;
    logic                 drain;
    logic                 commit_valid;
    logic [31:0]          size_wide;
    logic [SIZE_BITS-1:0] size_in;
    logic [31:0]          idx_wide;
    logic [31:0]          left_wide;

    // Token links between the cells; link 0 is the injection point.
    logic                 tok_valid [NUM_BLOCKS+1];
    logic                 tok_have  [NUM_BLOCKS+1];
    logic [IDX_W-1:0]     tok_idx   [NUM_BLOCKS+1];
    logic [SIZE_BITS-1:0] tok_left  [NUM_BLOCKS+1];
    logic [SIZE_BITS-1:0] tok_size  [NUM_BLOCKS+1];

    assign in_ready    = !busy_reg;
    assign accept      = in_valid && in_ready;
    assign place_start = accept && (operation == OP_PLACE);
    assign load_valid  = accept && (operation == OP_LOAD);

    // Request size reduced to the table's size width.
    assign size_wide = 32'(item_size);
    assign size_in   = size_wide[SIZE_BITS-1:0];

    assign tok_valid[0] = place_start;
    assign tok_have[0]  = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_left[0]  = '0;
    assign tok_size[0]  = size_in;

    // Row of block cells.
    for (genvar g = 0; g < NUM_BLOCKS; g++)
    begin : g_cell
        fpbp_cell #(
            .INDEX     (g),
            .IDX_W     (IDX_W),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .fit_policy    (fit_policy_reg),
            .blocks_in_use (blocks_in_use_reg),
            .load_valid    (load_valid),
            .load_index    (block_index),
            .load_size     (size_in),
            .commit_valid  (commit_valid),
            .commit_index  (pend_idx_reg),
            .tok_valid_in  (tok_valid[g]),
            .tok_have_in   (tok_have[g]),
            .tok_idx_in    (tok_idx[g]),
            .tok_left_in   (tok_left[g]),
            .tok_size_in   (tok_size[g]),
            .tok_valid_out (tok_valid[g+1]),
            .tok_have_out  (tok_have[g+1]),
            .tok_idx_out   (tok_idx[g+1]),
            .tok_left_out  (tok_left[g+1]),
            .tok_size_out  (tok_size[g+1])
        );
    end

    // A held result moves on when the output register is free or being taken.
    assign drain        = pend_valid_reg && (!out_valid_reg || out_ready);
    assign commit_valid = drain && pend_found_reg;

    always_comb
    begin
        priority if (place_start)
            busy_next = 1'b1;
        else if (drain)
            busy_next = 1'b0;
        else
            busy_next = busy_reg;
    end

    always_comb
    begin
        priority if (tok_valid[NUM_BLOCKS])
            pend_valid_next = 1'b1;
        else if (drain)
            pend_valid_next = 1'b0;
        else
            pend_valid_next = pend_valid_reg;
    end

    always_comb
    begin
        priority if (drain)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg    <= POLICY_FIRST;
            blocks_in_use_reg <= '0;
            busy_reg          <= 1'b0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == CFG_FIT_POLICY))
            begin
                fit_policy_reg <= policy_t'(cfg_data[1:0]);
            end
            if (cfg_write && (cfg_index == CFG_BLOCKS_IN_USE))
            begin
                blocks_in_use_reg <= cfg_data[COUNT_W-1:0];
            end
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result fields cut to the output widths.
    assign idx_wide  = 32'(pend_idx_reg);
    assign left_wide = 32'(pend_left_reg);

    always_ff @(posedge clk)
    begin
        if (tok_valid[NUM_BLOCKS])
        begin
            pend_found_reg <= tok_have[NUM_BLOCKS];
            pend_idx_reg   <= tok_idx[NUM_BLOCKS];
            pend_left_reg  <= tok_left[NUM_BLOCKS];
        end
        if (drain)
        begin
            found_reg    <= pend_found_reg;
            chosen_reg   <= idx_wide[BLOCK_FIELD_W-1:0];
            leftover_reg <= left_wide[SIZE_FIELD_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign chosen_block = chosen_reg;
    assign leftover     = leftover_reg;

endmodule

### tb/fit_policy_block_placement_tb.sv
`timescale 1ns / 100ps

module fit_policy_block_placement_tb;

    import fpbp_pkg::*;

    localparam int NUM_BLOCKS   = NUM_BLOCKS_DEF;
    localparam int DRAIN_SETTLE = 2 * NUM_BLOCKS + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 140;
    localparam int HOLD_OFF_LEN = 300;

    // Policy code with no rule of its own; it must act as first fit.
    localparam logic [1:0] POLICY_SPARE = 2'd3;

    // Register indexes that select nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_3 = 2'd3;

    // Settings visited by the random phases; the last phase is drawn at random.
    localparam logic [1:0] PHASE_POLICY [8] = '{POLICY_FIRST, POLICY_BEST, POLICY_WORST,
        POLICY_SPARE, POLICY_BEST, POLICY_WORST, POLICY_FIRST, POLICY_BEST};
    localparam logic [4:0] PHASE_COUNT [8] = '{5'd16, 5'd16, 5'd16, 5'd31, 5'd1, 5'd9,
        5'd17, 5'd16};

    typedef struct packed {
        logic                     found;
        logic [BLOCK_FIELD_W-1:0] block;
        logic [SIZE_FIELD_W-1:0]  left;
    } placement_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      operation;
    logic [BLOCK_FIELD_W-1:0]  block_index;
    logic [SIZE_FIELD_W-1:0]   item_size;
    logic                      out_valid;
    logic                      out_ready;
    logic                      found;
    logic [BLOCK_FIELD_W-1:0]  chosen_block;
    logic [SIZE_FIELD_W-1:0]   leftover;

    // Shadow copy of the block table, the used flags and both registers.
    logic [SIZE_FIELD_W-1:0]   size_table [NUM_BLOCKS];
    bit                        taken [NUM_BLOCKS];
    logic [1:0]                active_policy;
    logic [COUNT_W-1:0]        scan_count;

    placement_t                pending_placements [$];
    placement_t                due_result;
    int                        mismatch_count = 0;
    int                        cycle_count = 0;
    int                        hold_off_cycles = 0;
    bit                        sender_idles = 1'b1;
    bit                        receiver_idles = 1'b1;

    fit_policy_block_placement u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .block_index  (block_index),
        .item_size    (item_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .chosen_block (chosen_block),
        .leftover     (leftover)
    );

    always #6 clk = ~clk;

    // Works out the placement of one request and marks the chosen block used.
    function automatic placement_t predict_placement(logic [SIZE_FIELD_W-1:0] want);
        placement_t              pick;
        bit                      have;
        int                      limit;
        logic [SIZE_FIELD_W-1:0] left;
        pick  = '0;
        have  = 1'b0;
        limit = (scan_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_count);
        for (int i = 0; i < limit; i++)
        begin
            if (!taken[i] && size_table[i] >= want)
            begin
                left = size_table[i] - want;
                if (!have)
                begin
                    have       = 1'b1;
                    pick.found = 1'b1;
                    pick.block = i[BLOCK_FIELD_W-1:0];
                    pick.left  = left;
                    // First fit and the spare code stop at the first candidate.
                    if (active_policy != POLICY_BEST && active_policy != POLICY_WORST)
                        break;
                end
                else if (active_policy == POLICY_BEST && left < pick.left)
                begin
                    pick.block = i[BLOCK_FIELD_W-1:0];
                    pick.left  = left;
                end
                else if (active_policy == POLICY_WORST && left > pick.left)
                begin
                    pick.block = i[BLOCK_FIELD_W-1:0];
                    pick.left  = left;
                end
            end
        end
        if (have)
            taken[pick.block] = 1'b1;
        return pick;
    endfunction

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Block sizes lean towards small values so that ties and exact fits occur.
    function automatic logic [SIZE_FIELD_W-1:0] pick_block_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        else if (roll < 6)
            return SIZE_FIELD_W'($urandom_range(0, 48));
        else
            return SIZE_FIELD_W'($urandom);
    endfunction

    // Request sizes mix exact copies of table entries, small and full-range values.
    function automatic logic [SIZE_FIELD_W-1:0] pick_request_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        else if (roll < 4)
            return size_table[BLOCK_FIELD_W'($urandom_range(0, NUM_BLOCKS - 1))];
        else if (roll < 7)
            return SIZE_FIELD_W'($urandom_range(0, 40));
        else
            return SIZE_FIELD_W'($urandom);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Register write; the shadow copy follows the registers that exist.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_FIT_POLICY)
            active_policy = value[1:0];
        else if (idx == CFG_BLOCKS_IN_USE)
            scan_count = value;
        @(posedge clk);
    endtask

    // Offers one request, holds it until taken, then updates the shadow state.
    task automatic send_request(input logic op, input logic [BLOCK_FIELD_W-1:0] idx,
                                input logic [SIZE_FIELD_W-1:0] size);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        block_index <= idx;
        item_size   <= size;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op == OP_PLACE)
        begin
            pending_placements.push_back(predict_placement(size));
        end
        else
        begin
            size_table[idx] = size;
            taken[idx]      = 1'b0;
        end
    endtask

    // Stops sending until every placement has come back and the block is quiet.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // Random loads and place requests, with the odd burst of loads to refill.
    task automatic run_placement_mix(input int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                for (int j = 0; j < 4; j++)
                    send_request(OP_LOAD, BLOCK_FIELD_W'($urandom_range(0, NUM_BLOCKS - 1)),
                                 pick_block_size());
            end
            else if ($urandom_range(0, 9) < 4)
            begin
                send_request(OP_LOAD, BLOCK_FIELD_W'($urandom_range(0, NUM_BLOCKS - 1)),
                             pick_block_size());
            end
            else
            begin
                send_request(OP_PLACE, BLOCK_FIELD_W'($urandom_range(0, NUM_BLOCKS - 1)),
                             pick_request_size());
            end
        end
    endtask

    // Hand-picked table and requests for each policy and the corner cases.
    task automatic test_directed_cases();
        logic [SIZE_FIELD_W-1:0] sizes [NUM_BLOCKS];
        sizes = '{16'd100, 16'd40, 16'd0, 16'hFFFF, 16'd40, 16'd200, 16'd40, 16'd7,
                  16'd300, 16'd40, 16'd12, 16'hFFFF, 16'd5, 16'd40, 16'd999, 16'd1};
        // Nothing is scanned while the count is still zero after reset.
        send_request(OP_PLACE, 4'd0, 16'd0);
        for (int i = 0; i < NUM_BLOCKS; i++)
            send_request(OP_LOAD, i[BLOCK_FIELD_W-1:0], sizes[i]);
        wait_for_results();
        write_register(CFG_BLOCKS_IN_USE, 5'd16);
        send_request(OP_PLACE, 4'hF, 16'd40);
        send_request(OP_PLACE, 4'h0, 16'd0);
        wait_for_results();
        // Writes to the reserved indexes must leave both registers alone.
        write_register(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_BEST));
        write_register(CFG_RESERVED_2, 5'h1F);
        write_register(CFG_RESERVED_3, 5'h00);
        send_request(OP_PLACE, 4'h0, 16'd40);
        send_request(OP_PLACE, 4'h0, 16'hFFFF);
        send_request(OP_PLACE, 4'h0, 16'hFFFF);
        wait_for_results();
        write_register(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_WORST));
        send_request(OP_PLACE, 4'h0, 16'd0);
        wait_for_results();
        write_register(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_SPARE));
        send_request(OP_PLACE, 4'h0, 16'd10);
        wait_for_results();
        // A count above the table size scans the whole table.
        write_register(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_BEST));
        write_register(CFG_BLOCKS_IN_USE, 5'd31);
        send_request(OP_PLACE, 4'h0, 16'd1);
        wait_for_results();
        // Only block 0 is scanned and it is already used, so nothing fits.
        write_register(CFG_BLOCKS_IN_USE, 5'd1);
        send_request(OP_PLACE, 4'h0, 16'd0);
    endtask

    // Several settings, each run in two halves with a full drain between them.
    task automatic test_random_phases();
        for (int p = 0; p < 8; p++)
        begin
            wait_for_results();
            if (p == 7)
            begin
                write_register(CFG_FIT_POLICY, CFG_DATA_W'($urandom_range(0, 3)));
                write_register(CFG_BLOCKS_IN_USE, CFG_DATA_W'($urandom_range(2, 31)));
            end
            else
            begin
                write_register(CFG_FIT_POLICY, CFG_DATA_W'(PHASE_POLICY[p]));
                write_register(CFG_BLOCKS_IN_USE, PHASE_COUNT[p]);
            end
            // The first phase runs with no idling on either side.
            sender_idles   = (p != 0) && ($urandom_range(0, 3) != 0);
            receiver_idles = (p != 0) && ($urandom_range(0, 3) != 0);
            run_placement_mix(PHASE_ITEMS / 2);
            wait_for_results();
            run_placement_mix(PHASE_ITEMS / 2);
        end
    endtask

    // The receiver holds off while requests keep coming, so the block backs up.
    task automatic test_receiver_hold_off();
        wait_for_results();
        write_register(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_BEST));
        write_register(CFG_BLOCKS_IN_USE, 5'd16);
        sender_idles   = 1'b0;
        receiver_idles = 1'b1;
        for (int i = 0; i < NUM_BLOCKS; i++)
            send_request(OP_LOAD, i[BLOCK_FIELD_W-1:0], SIZE_FIELD_W'($urandom_range(0, 60)));
        hold_off_cycles = HOLD_OFF_LEN;
        for (int k = 0; k < 24; k++)
            send_request(OP_PLACE, BLOCK_FIELD_W'($urandom_range(0, NUM_BLOCKS - 1)),
                         SIZE_FIELD_W'($urandom_range(0, 40)));
        wait_for_results();
    endtask

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                out_ready <= 1'b0;
                while (hold_off_cycles != 0)
                begin
                    @(posedge clk);
                    hold_off_cycles--;
                end
                out_ready <= 1'b1;
            end
            else if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Each result taken is compared with the oldest outstanding placement.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_placements.size() == 0)
            begin
                flag_mismatch("result arrived with no place request outstanding");
            end
            else
            begin
                due_result = pending_placements.pop_front();
                if (found !== due_result.found)
                    flag_mismatch($sformatf("found %0b, expected %0b",
                                            found, due_result.found));
                if (chosen_block !== due_result.block)
                    flag_mismatch($sformatf("chosen_block %0d, expected %0d",
                                            chosen_block, due_result.block));
                if (leftover !== due_result.left)
                    flag_mismatch($sformatf("leftover %0d, expected %0d",
                                            leftover, due_result.left));
            end
        end
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_placements.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        operation   <= OP_LOAD;
        block_index <= '0;
        item_size   <= '0;
        active_policy = POLICY_FIRST;
        scan_count    = '0;
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            size_table[i] = '0;
            taken[i]      = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_phases();
        test_receiver_hold_off();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
